FILE: src/acfce_pkg.sv
package acfce_pkg;

    localparam int PcWidth = 5;

    typedef struct packed {
        logic [7:0] command_code;
        logic [1:0] arg_count;
        logic [7:0] first_arg;
        logic [7:0] second_arg;
    } acfce_in_t;

    typedef struct packed {
        logic [7:0] frame_byte;
        logic       last_byte;
        logic       bad_request;
        logic       expects_reply;
    } acfce_out_t;

    // byte source of one step
    typedef enum logic [3:0] {
        SRC_LIT,
        SRC_CMD_HI,
        SRC_CMD_LO,
        SRC_A0_HI,
        SRC_A0_LO,
        SRC_A1_HI,
        SRC_A1_LO,
        SRC_CRC_3,
        SRC_CRC_2,
        SRC_CRC_1,
        SRC_CRC_0
    } acfce_src_t;

    // jump conditions, tested after the step
    typedef enum logic [1:0] {
        JC_NONE,
        JC_BAD,
        JC_CNT0,
        JC_CNT1
    } acfce_jc_t;

    typedef struct packed {
        logic               emit;
        acfce_src_t         src;
        logic [7:0]         lit;
        logic               crc_en;
        logic               skip_zero;
        logic               last;
        logic               bad;
        acfce_jc_t          jc;
        logic [PcWidth-1:0] target;
        logic               done;
    } acfce_cw_t;

    typedef struct packed {
        logic      load;
        logic      exec;
        acfce_cw_t cw;
    } acfce_ctl_t;

    typedef struct packed {
        logic bad;
        logic cnt0;
        logic cnt1;
        logic out_free;
    } acfce_flags_t;

    localparam logic [PcWidth-1:0] PcCrc = 5'd20;
    localparam logic [PcWidth-1:0] PcErr = 5'd26;

    function automatic logic [7:0] hex_char(input logic [3:0] n);
        logic [7:0] c;
        if (n < 4'd10)
        begin
            c = 8'h30 + {4'h0, n};
        end
        else
        begin
            c = 8'h57 + {4'h0, n};
        end
        return c;
    endfunction

    function automatic logic [15:0] crc_byte(input logic [15:0] crc_in, input logic [7:0] b);
        logic [15:0] c;
        c = crc_in ^ {b, 8'h00};
        for (int i = 0; i < 8; i++)
        begin
            if (c[15])
            begin
                c = {c[14:0], 1'b0} ^ 16'h1021;
            end
            else
            begin
                c = {c[14:0], 1'b0};
            end
        end
        return c;
    endfunction

    function automatic logic silent_command(input logic [7:0] cmd);
        return cmd == 8'd7 || cmd == 8'd9 || cmd == 8'd10 ||
               cmd == 8'd12 || cmd == 8'd15 || cmd == 8'd16;
    endfunction

    function automatic acfce_cw_t cw_lit(input logic [7:0] c, input logic crc);
        acfce_cw_t w;
        w = '0;
        w.emit = 1'b1;
        w.src = SRC_LIT;
        w.lit = c;
        w.crc_en = crc;
        w.jc = JC_NONE;
        return w;
    endfunction

    function automatic acfce_cw_t cw_nib(input acfce_src_t s, input logic crc,
                                         input logic skip);
        acfce_cw_t w;
        w = '0;
        w.emit = 1'b1;
        w.src = s;
        w.crc_en = crc;
        w.skip_zero = skip;
        w.jc = JC_NONE;
        return w;
    endfunction

    // microprogram
    function automatic acfce_cw_t ucode(input logic [PcWidth-1:0] pc);
        acfce_cw_t w;
        w = '0;
        case (pc)
            5'd0:
            begin
                w.jc = JC_BAD;
                w.target = PcErr;
            end
            5'd1:  w = cw_lit("u", 1'b1);
            5'd2:  w = cw_lit("a", 1'b1);
            5'd3:  w = cw_lit("r", 1'b1);
            5'd4:  w = cw_lit("t", 1'b1);
            5'd5:  w = cw_lit("_", 1'b1);
            5'd6:  w = cw_lit("0", 1'b1);
            5'd7:  w = cw_lit("x", 1'b1);
            5'd8:  w = cw_nib(SRC_CMD_HI, 1'b1, 1'b0);
            5'd9:
            begin
                w = cw_nib(SRC_CMD_LO, 1'b1, 1'b0);
                w.jc = JC_CNT0;
                w.target = PcCrc;
            end
            5'd10: w = cw_lit("_", 1'b1);
            5'd11: w = cw_lit("0", 1'b1);
            5'd12: w = cw_lit("x", 1'b1);
            5'd13: w = cw_nib(SRC_A0_HI, 1'b1, 1'b0);
            5'd14:
            begin
                w = cw_nib(SRC_A0_LO, 1'b1, 1'b0);
                w.jc = JC_CNT1;
                w.target = PcCrc;
            end
            5'd15: w = cw_lit("_", 1'b1);
            5'd16: w = cw_lit("0", 1'b1);
            5'd17: w = cw_lit("x", 1'b1);
            5'd18: w = cw_nib(SRC_A1_HI, 1'b1, 1'b0);
            5'd19: w = cw_nib(SRC_A1_LO, 1'b1, 1'b0);
            5'd20: w = cw_lit("_", 1'b0);
            5'd21: w = cw_nib(SRC_CRC_3, 1'b0, 1'b1);
            5'd22: w = cw_nib(SRC_CRC_2, 1'b0, 1'b0);
            5'd23: w = cw_nib(SRC_CRC_1, 1'b0, 1'b1);
            5'd24: w = cw_nib(SRC_CRC_0, 1'b0, 1'b0);
            5'd25:
            begin
                w = cw_lit("#", 1'b0);
                w.last = 1'b1;
                w.done = 1'b1;
            end
            5'd26:
            begin
                w = cw_lit(8'h00, 1'b0);
                w.last = 1'b1;
                w.bad = 1'b1;
                w.done = 1'b1;
            end
            default:
            begin
                w.done = 1'b1;
            end
        endcase
        return w;
    endfunction

endpackage

FILE: src/acfce_sequencer.sv
module acfce_sequencer (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  acfce_pkg::acfce_flags_t flags,
    output acfce_pkg::acfce_ctl_t   ctl
);
    import acfce_pkg::*;

    logic               busy_reg, busy_next;
    logic [PcWidth-1:0] pc_reg, pc_next;
    acfce_cw_t          cw;
    logic               taken;

    assign cw = ucode(pc_reg);
    assign in_ready = !busy_reg;
    assign ctl.load = in_valid && !busy_reg;
    assign ctl.exec = busy_reg && flags.out_free;
    assign ctl.cw = cw;

    always_comb
    begin
        case (cw.jc)
            JC_BAD:  taken = flags.bad;
            JC_CNT0: taken = flags.cnt0;
            JC_CNT1: taken = flags.cnt1;
            default: taken = 1'b0;
        endcase
    end

    always_comb
    begin
        busy_next = busy_reg;
        pc_next = pc_reg;
        if (ctl.load)
        begin
            busy_next = 1'b1;
            pc_next = '0;
        end
        else if (ctl.exec)
        begin
            if (cw.done)
            begin
                busy_next = 1'b0;
            end
            else if (taken)
            begin
                pc_next = cw.target;
            end
            else
            begin
                pc_next = pc_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            pc_reg <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            pc_reg <= pc_next;
        end
    end

endmodule

FILE: src/acfce_datapath.sv
module acfce_datapath (
    input  logic                    clk,
    input  logic                    rst_n,
    input  acfce_pkg::acfce_in_t    in_data,
    input  acfce_pkg::acfce_ctl_t   ctl,
    output acfce_pkg::acfce_flags_t flags,
    output logic                    out_valid,
    input  logic                    out_ready,
    output acfce_pkg::acfce_out_t   out_data
);
    import acfce_pkg::*;

    acfce_in_t   req_reg;
    logic [15:0] crc_reg, crc_next;
    logic        out_valid_reg, out_valid_next;
    acfce_out_t  out_data_reg, out_data_next;
    logic [3:0]  nib;
    logic [7:0]  byte_val;
    logic        emit;

    assign flags.bad = req_reg.arg_count == 2'd3;
    assign flags.cnt0 = req_reg.arg_count == 2'd0;
    assign flags.cnt1 = req_reg.arg_count == 2'd1;
    assign flags.out_free = !out_valid_reg || out_ready;

    always_comb
    begin
        case (ctl.cw.src)
            SRC_CMD_HI: nib = req_reg.command_code[7:4];
            SRC_CMD_LO: nib = req_reg.command_code[3:0];
            SRC_A0_HI:  nib = req_reg.first_arg[7:4];
            SRC_A0_LO:  nib = req_reg.first_arg[3:0];
            SRC_A1_HI:  nib = req_reg.second_arg[7:4];
            SRC_A1_LO:  nib = req_reg.second_arg[3:0];
            SRC_CRC_3:  nib = crc_reg[15:12];
            SRC_CRC_2:  nib = crc_reg[11:8];
            SRC_CRC_1:  nib = crc_reg[7:4];
            SRC_CRC_0:  nib = crc_reg[3:0];
            default:    nib = 4'h0;
        endcase
    end

    assign byte_val = (ctl.cw.src == SRC_LIT) ? ctl.cw.lit : hex_char(nib);
    // unpadded crc digits drop a leading zero
    assign emit = ctl.exec && ctl.cw.emit && !(ctl.cw.skip_zero && nib == 4'h0);

    always_comb
    begin
        crc_next = crc_reg;
        if (ctl.load)
        begin
            crc_next = '0;
        end
        else if (emit && ctl.cw.crc_en)
        begin
            crc_next = crc_byte(crc_reg, byte_val);
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        out_data_next = out_data_reg;
        if (emit)
        begin
            out_valid_next = 1'b1;
            out_data_next.frame_byte = byte_val;
            out_data_next.last_byte = ctl.cw.last;
            out_data_next.bad_request = ctl.cw.bad;
            out_data_next.expects_reply = !silent_command(req_reg.command_code);
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.load)
        begin
            req_reg <= in_data;
        end
        crc_reg <= crc_next;
        out_data_reg <= out_data_next;
    end

    assign out_valid = out_valid_reg;
    assign out_data = out_data_reg;

endmodule

FILE: src/ascii_command_frame_crc_encoder_top.sv
// ascii command frame encoder: each request (command byte plus zero to two
// argument bytes) becomes the text frame "uart_0xCC[_0xAA[_0xBB]]_<crc>#",
// one character per output transfer, with a crc-16/xmodem (poly 0x1021,
// init 0) over the text before the underscore that leads the crc field,
// written as unpadded lowercase hex of its high then low byte. arg_count
// of 3 yields a single transfer with frame_byte 0, bad_request and
// last_byte set. every transfer carries expects_reply for the command. a
// microprogram of 27 steps in a constant rom drives the datapath; each
// step emits at most one character, and a dropped leading crc digit
// still spends its step. output stalls hold the walk through the rom. a
// new request is taken only after the previous frame's last character
// is registered.
module ascii_command_frame_crc_encoder_top (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  acfce_pkg::acfce_in_t  in_data,
    output logic                  out_valid,
    input  logic                  out_ready,
    output acfce_pkg::acfce_out_t out_data
);
    import acfce_pkg::*;

    // control word and datapath status between the two halves
    acfce_ctl_t   ctl;
    acfce_flags_t flags;

    // step counter, rom and jump logic
    acfce_sequencer u_seq (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .flags    (flags),
        .ctl      (ctl)
    );

    // request capture, hex conversion, crc and output register
    acfce_datapath u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_data   (in_data),
        .ctl       (ctl),
        .flags     (flags),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

endmodule
